[src/xcrc_pkg.sv]
// Shared constants, types and the byte-wide CRC-16 update for the Xmodem-CRC receiver.
// Used by xcrc_commit_addr and xmodem_crc_packet_receiver_core; depends on nothing else.
`default_nettype none

package xcrc_pkg;

    // Page and slot sizes are powers of two.
    localparam int PAGE_BYTES   = 1024;
    localparam int SLOT_BYTES   = 65536;
    localparam int PKT_PER_PAGE = PAGE_BYTES / 128;
    localparam int PPP_BITS     = $clog2(PKT_PER_PAGE);
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int SLOT_BITS    = $clog2(SLOT_BYTES);

    localparam logic [10:0] COMMIT_FULL_LEN = 11'(PAGE_BYTES % 2048);

    localparam logic [7:0]  BYTE_SOH = 8'h01;
    localparam logic [7:0]  BYTE_EOT = 8'h04;
    localparam logic [7:0]  BYTE_ACK = 8'h06;
    localparam logic [7:0]  BYTE_NAK = 8'h15;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] POS_DATA_FIRST = 8'd3;
    localparam logic [7:0] POS_DATA_LAST  = 8'd130;
    localparam logic [7:0] POS_CRC_HIGH   = 8'd131;
    localparam logic [7:0] POS_CRC_LOW    = 8'd132;
    localparam logic [7:0] POS_MAX        = 8'd255;

    localparam logic [1:0] CFG_TARGET_EXTERNAL = 2'd0;
    localparam logic [1:0] CFG_EXTERNAL_SLOT   = 2'd1;
    localparam logic [1:0] CFG_INTERNAL_BASE   = 2'd2;

    localparam logic [31:0] INTERNAL_BASE_RESET = 32'h0800_4000;

    typedef struct packed {
        logic        target_external;
        logic [3:0]  external_slot;
        logic [31:0] internal_base;
    } cfg_t;

    typedef struct packed {
        logic        stage_valid;
        logic [9:0]  stage_offset;
        logic [7:0]  stage_byte;
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        commit_valid;
        logic [31:0] commit_addr;
        logic [10:0] commit_len;
        logic        transfer_done;
        logic [22:0] image_bytes;
    } res_t;

    // MSB-first CRC-16 update by one byte.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/xmodem_crc_packet_receiver_core.sv]
// Xmodem-CRC packet receiver: one word in per received byte, one result word out per byte.
// A result word is formed from the input register and held in the result register until it is taken.
// Throughput is one word per cycle while out_stall is low, set by the byte-wide CRC-16 update done combinationally.
// An input register and a result register part the two channels, so a byte is taken while a result waits.
// Reset clears all protocol state and the valid flags and loads the configuration defaults.
// Depends on xcrc_pkg and xcrc_commit_addr.
`default_nettype none

module xmodem_crc_packet_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        stage_valid,
    output logic [9:0]  stage_offset,
    output logic [7:0]  stage_byte,
    output logic        reply_valid,
    output logic [7:0]  reply_byte,
    output logic        commit_valid,
    output logic [31:0] commit_addr,
    output logic [10:0] commit_len,
    output logic        transfer_done,
    output logic [22:0] image_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import xcrc_pkg::*;

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eom_reg;
    logic        out_valid_reg;
    res_t        res_reg;
    res_t        res_next;

    logic [15:0] crc_accum_reg, crc_accum_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic        first_soh_reg, first_soh_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [15:0] packet_count_reg, packet_count_next;
    logic        finished_reg, finished_next;

    logic                advance;
    logic                in_fire;
    logic                soh_cur;
    logic [15:0]         crc_cur;
    logic [15:0]         crc_upd;
    logic                in_data;
    logic [7:0]          pos_m3;
    logic [PPP_BITS-1:0] page_slot;
    logic [15:0]         count_inc;
    logic [31:0]         off_wide;
    logic [31:0]         rem_len_wide;
    logic [31:0]         page_index;
    logic [31:0]         page_addr;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // A full page closes the page before the new count; the end of transfer uses the open one.
    assign page_index = (byte_pos_reg == 8'd0) ? 32'(packet_count_reg >> PPP_BITS)
                                               : 32'(count_inc >> PPP_BITS) - 32'd1;

    xcrc_commit_addr u_commit_addr (
        .cfg        (cfg_reg),
        .page_index (page_index),
        .addr       (page_addr)
    );

    assign soh_cur      = (byte_pos_reg == 8'd0) ? (s1_byte_reg == BYTE_SOH) : first_soh_reg;
    assign crc_cur      = (byte_pos_reg == 8'd0) ? 16'h0000 : crc_accum_reg;
    assign crc_upd      = crc16_step(crc_cur, s1_byte_reg);
    assign in_data      = (byte_pos_reg >= POS_DATA_FIRST) && (byte_pos_reg <= POS_DATA_LAST);
    assign pos_m3       = byte_pos_reg - POS_DATA_FIRST;
    assign page_slot    = packet_count_reg[PPP_BITS-1:0];
    assign count_inc    = packet_count_reg + 16'd1;
    assign off_wide     = (32'(page_slot) << 7) | 32'(pos_m3[6:0]);
    assign rem_len_wide = 32'(page_slot) << 7;

    always_comb
    begin
        crc_accum_next    = crc_accum_reg;
        byte_pos_next     = byte_pos_reg;
        first_soh_next    = first_soh_reg;
        crc_high_next     = crc_high_reg;
        packet_count_next = packet_count_reg;
        finished_next     = finished_reg;
        res_next          = '0;
        if (!finished_reg)
        begin
            first_soh_next = soh_cur;
            crc_accum_next = in_data ? crc_upd : crc_cur;
            if (in_data && soh_cur)
            begin
                res_next.stage_valid  = 1'b1;
                res_next.stage_offset = off_wide[9:0];
                res_next.stage_byte   = s1_byte_reg;
            end
            if (byte_pos_reg == POS_CRC_HIGH)
            begin
                crc_high_next = s1_byte_reg;
            end
            if (s1_eom_reg)
            begin
                if ((byte_pos_reg == POS_CRC_LOW) && soh_cur)
                begin
                    res_next.reply_valid = 1'b1;
                    if ({crc_high_reg, s1_byte_reg} == crc_cur)
                    begin
                        packet_count_next   = count_inc;
                        res_next.reply_byte = BYTE_ACK;
                        if (count_inc[PPP_BITS-1:0] == '0)
                        begin
                            res_next.commit_valid = 1'b1;
                            res_next.commit_addr  = page_addr;
                            res_next.commit_len   = COMMIT_FULL_LEN;
                        end
                    end
                    else
                    begin
                        res_next.reply_byte = BYTE_NAK;
                    end
                end
                else if ((byte_pos_reg == 8'd0) && (s1_byte_reg == BYTE_EOT))
                begin
                    res_next.reply_valid = 1'b1;
                    res_next.reply_byte  = BYTE_ACK;
                    if (page_slot != '0)
                    begin
                        res_next.commit_valid = 1'b1;
                        res_next.commit_addr  = page_addr;
                        res_next.commit_len   = rem_len_wide[10:0];
                    end
                    res_next.transfer_done = 1'b1;
                    res_next.image_bytes   = {packet_count_reg, 7'b0};
                    finished_next          = 1'b1;
                end
                byte_pos_next = 8'd0;
            end
            else if (byte_pos_reg != POS_MAX)
            begin
                byte_pos_next = byte_pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_external <= 1'b0;
            cfg_reg.external_slot   <= 4'd0;
            cfg_reg.internal_base   <= INTERNAL_BASE_RESET;
            s1_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            crc_accum_reg           <= 16'h0000;
            byte_pos_reg            <= 8'd0;
            first_soh_reg           <= 1'b0;
            crc_high_reg            <= 8'd0;
            packet_count_reg        <= 16'd0;
            finished_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TARGET_EXTERNAL: cfg_reg.target_external <= cfg_data[0];
                    CFG_EXTERNAL_SLOT:   cfg_reg.external_slot   <= cfg_data[3:0];
                    CFG_INTERNAL_BASE:   cfg_reg.internal_base   <= cfg_data;
                    default:             cfg_reg                 <= cfg_reg;
                endcase
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                crc_accum_reg    <= crc_accum_next;
                byte_pos_reg     <= byte_pos_next;
                first_soh_reg    <= first_soh_next;
                crc_high_reg     <= crc_high_next;
                packet_count_reg <= packet_count_next;
                finished_reg     <= finished_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= rx_byte;
            s1_eom_reg  <= end_of_message;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign stage_valid   = res_reg.stage_valid;
    assign stage_offset  = res_reg.stage_offset;
    assign stage_byte    = res_reg.stage_byte;
    assign reply_valid   = res_reg.reply_valid;
    assign reply_byte    = res_reg.reply_byte;
    assign commit_valid  = res_reg.commit_valid;
    assign commit_addr   = res_reg.commit_addr;
    assign commit_len    = res_reg.commit_len;
    assign transfer_done = res_reg.transfer_done;
    assign image_bytes   = res_reg.image_bytes;

    // A commit or the end of the transfer is always acknowledged.
    a_commit_acked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (commit_valid || transfer_done) |-> reply_valid && (reply_byte == BYTE_ACK))
        else $error("commit or transfer end without an acknowledge");

    // Staging and replies come from different byte positions of a message.
    a_stage_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stage_valid |-> !reply_valid && !commit_valid)
        else $error("staged byte and reply in the same result word");

    // Once the transfer has finished, every later result word is empty.
    a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg && advance |=> out_valid && !stage_valid && !reply_valid && !commit_valid)
        else $error("result word carries data after the transfer finished");

    // The packet counter moves only on an acknowledged data packet.
    a_count_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        packet_count_reg != $past(packet_count_reg) |-> out_valid && reply_valid
            && (reply_byte == BYTE_ACK) && !transfer_done)
        else $error("packet counter changed without an acknowledged packet");

    // The input side stalls only while a word sits in the input register.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with no word held");

endmodule

`default_nettype wire

[src/xcrc_commit_addr.sv]
// Flash address of a page commit, internal from the base or external by slot.
// Depends on xcrc_pkg for the configuration struct and the page and slot sizes.
`default_nettype none

module xcrc_commit_addr (
    input  xcrc_pkg::cfg_t cfg,
    input  logic [31:0]    page_index,
    output logic [31:0]    addr
);
    import xcrc_pkg::*;

    logic [31:0] page_off;
    logic [31:0] slot_start;
    logic [31:0] start;

    assign page_off   = page_index << PAGE_BITS;
    assign slot_start = 32'(cfg.external_slot) << SLOT_BITS;
    assign start      = cfg.target_external ? slot_start : cfg.internal_base;
    assign addr       = start + page_off;

endmodule

`default_nettype wire
